// ===== src/sorted_timeout_queue_macros.svh =====
// Assertion macros shared by the checker.
`ifndef SORTED_TIMEOUT_QUEUE_MACROS_SVH
`define SORTED_TIMEOUT_QUEUE_MACROS_SVH
`define STQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define STQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== src/stq_pkg.sv =====
package stq_pkg;
    localparam int SLOTS = 16;
    localparam int SLOT_BITS = 4;
    localparam int TICK_BITS = 32;
    localparam int CNT_BITS = 5;

    localparam logic [1:0] FUNC_INSERT  = 2'd0;
    localparam logic [1:0] FUNC_REMOVE  = 2'd1;
    localparam logic [1:0] FUNC_ADVANCE = 2'd2;
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_ARG   = 2'd1;
    localparam logic [1:0] ST_BAD_STATE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SCAN,
        S_REM_SCAN,
        S_ADV_SCAN,
        S_ADV_EMIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]           status;
        logic                 expired_valid;
        logic [SLOT_BITS-1:0] expired_slot;
        logic [TICK_BITS-1:0] expired_wake;
        logic                 last_result;
        logic [CNT_BITS-1:0]  pending_count;
        logic [TICK_BITS-1:0] stored_time;
    } result_t;
endpackage

// ===== src/stq_outreg.sv =====
module stq_outreg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  stq_pkg::result_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output stq_pkg::result_t  out_data
);
    logic             valid_reg;
    stq_pkg::result_t data_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= in_data;
        end
    end
endmodule

// ===== src/stq_core.sv =====
module stq_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [stq_pkg::TICK_BITS-1:0]      cfg_wr_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         in_func,
    input  logic [stq_pkg::SLOT_BITS-1:0]      in_slot,
    input  logic [stq_pkg::TICK_BITS-1:0]      in_delay,
    input  logic [stq_pkg::TICK_BITS-1:0]      in_now,
    output logic                               res_valid,
    input  logic                               res_ready,
    output stq_pkg::result_t                   res_data
);
    localparam int SB = stq_pkg::SLOT_BITS;
    localparam int TB = stq_pkg::TICK_BITS;
    localparam int CB = stq_pkg::CNT_BITS;
    localparam int N  = stq_pkg::SLOTS;

    stq_pkg::state_t state_reg, state_next;

    // Lists are kept as register rows; each entry is read at its own fixed position
    // during shifts, and at the scan position by the shared compare.
    logic [SB-1:0] order_reg [2][N];
    logic [TB-1:0] wake_reg [N];
    logic [N-1:0]  armed_reg;
    logic [N-1:0]  inlist_reg;
    logic [CB-1:0] len_reg [2];
    logic          cur_reg;
    logic [TB-1:0] time_reg;
    logic [CB-1:0] total_reg;

    logic [SB-1:0] slot_reg;
    logic [TB-1:0] key_reg;
    logic          lsel_reg;
    logic [CB-1:0] pos_reg;
    logic [CB-1:0] cnt_reg;
    logic          bad_arg_reg;
    logic          bad_state_reg;

    logic [TB:0]   sum_ext;
    logic [TB-1:0] sum;
    logic          wrapped;
    logic          time_back;
    logic          accept;
    logic          bad_arg, bad_state;
    logic [CB-1:0] cur_len;
    logic          scan_end;
    logic [SB-1:0] scan_slot;
    logic [TB-1:0] scan_wake;
    logic          key_lt;
    logic [SB-1:0] head_slot;

    // The carry out of the wake sum marks a wake tick that wrapped past zero.
    assign sum_ext   = {1'b0, time_reg} + {1'b0, in_delay};
    assign sum       = sum_ext[TB-1:0];
    assign wrapped   = sum_ext[TB];
    assign time_back = (in_now < time_reg);

    assign cur_len   = len_reg[lsel_reg];
    assign scan_end  = (pos_reg >= cur_len);
    assign scan_slot = order_reg[lsel_reg][pos_reg[SB-1:0]];
    assign scan_wake = wake_reg[scan_slot];
    assign key_lt    = (key_reg < scan_wake);
    assign head_slot = order_reg[lsel_reg][0];

    always_comb begin
        bad_arg   = 1'b0;
        bad_state = 1'b0;
        unique case (in_func)
            stq_pkg::FUNC_INSERT: begin
                bad_arg   = (in_delay == '1);
                bad_state = armed_reg[in_slot];
            end
            stq_pkg::FUNC_REMOVE: begin
                bad_state = !armed_reg[in_slot];
            end
            stq_pkg::FUNC_ADVANCE: begin
            end
            default: begin
                bad_arg = 1'b1;
            end
        endcase
    end

    assign in_ready = (state_reg == stq_pkg::S_IDLE) && !cfg_wr_en;
    assign accept   = in_valid && in_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stq_pkg::S_IDLE: begin
                if (accept) begin
                    if (bad_arg || bad_state) begin
                        state_next = stq_pkg::S_OUT;
                    end else if (in_func == stq_pkg::FUNC_INSERT) begin
                        state_next = stq_pkg::S_INS_SCAN;
                    end else if (in_func == stq_pkg::FUNC_REMOVE) begin
                        state_next = stq_pkg::S_REM_SCAN;
                    end else begin
                        state_next = stq_pkg::S_ADV_SCAN;
                    end
                end
            end
            stq_pkg::S_INS_SCAN: begin
                if (scan_end || key_lt) begin
                    state_next = stq_pkg::S_OUT;
                end
            end
            stq_pkg::S_REM_SCAN: begin
                if (scan_end || scan_slot == slot_reg) begin
                    state_next = stq_pkg::S_OUT;
                end
            end
            stq_pkg::S_ADV_SCAN: begin
                if (scan_end || key_lt) begin
                    state_next = (cnt_reg == '0) ? stq_pkg::S_OUT : stq_pkg::S_ADV_EMIT;
                end
            end
            stq_pkg::S_ADV_EMIT: begin
                if (res_ready && cnt_reg == CB'(1)) begin
                    state_next = stq_pkg::S_IDLE;
                end
            end
            stq_pkg::S_OUT: begin
                if (res_ready) begin
                    state_next = stq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = stq_pkg::S_IDLE;
            end
        endcase
    end

    // During an advance the count and the total fall together, so their difference
    // is the number of armed slots left once the whole advance is done.
    always_comb begin
        res_valid = 1'b0;
        res_data  = '0;
        res_data.pending_count = total_reg;
        res_data.stored_time   = time_reg;
        res_data.last_result   = 1'b1;
        unique case (state_reg)
            stq_pkg::S_OUT: begin
                res_valid = 1'b1;
                res_data.status = bad_state_reg ? stq_pkg::ST_BAD_STATE :
                                  bad_arg_reg ? stq_pkg::ST_BAD_ARG : stq_pkg::ST_OK;
            end
            stq_pkg::S_ADV_EMIT: begin
                res_valid = 1'b1;
                res_data.expired_valid = 1'b1;
                res_data.expired_slot  = head_slot;
                res_data.expired_wake  = wake_reg[head_slot];
                res_data.last_result   = (cnt_reg == CB'(1));
                res_data.pending_count = total_reg - cnt_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stq_pkg::S_IDLE;
        end else if (cfg_wr_en) begin
            state_reg <= stq_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg   <= '0;
            armed_reg  <= '0;
            len_reg[0] <= '0;
            len_reg[1] <= '0;
            cur_reg    <= 1'b0;
            total_reg  <= '0;
        end else if (cfg_wr_en) begin
            time_reg   <= cfg_wr_data;
            armed_reg  <= '0;
            len_reg[0] <= '0;
            len_reg[1] <= '0;
            cur_reg    <= 1'b0;
            total_reg  <= '0;
        end else begin
            unique case (state_reg)
                stq_pkg::S_IDLE: begin
                    if (accept && in_func == stq_pkg::FUNC_ADVANCE) begin
                        if (time_back) begin
                            cur_reg <= !cur_reg;
                        end
                        time_reg <= in_now;
                    end
                end
                stq_pkg::S_INS_SCAN: begin
                    if (scan_end || key_lt) begin
                        len_reg[lsel_reg]   <= cur_len + CB'(1);
                        armed_reg[slot_reg] <= 1'b1;
                        total_reg           <= total_reg + CB'(1);
                    end
                end
                stq_pkg::S_REM_SCAN: begin
                    if (scan_end || scan_slot == slot_reg) begin
                        if (!scan_end) begin
                            len_reg[lsel_reg] <= cur_len - CB'(1);
                        end
                        armed_reg[slot_reg] <= 1'b0;
                        total_reg           <= total_reg - CB'(1);
                    end
                end
                stq_pkg::S_ADV_EMIT: begin
                    if (res_ready) begin
                        len_reg[lsel_reg]    <= cur_len - CB'(1);
                        armed_reg[head_slot] <= 1'b0;
                        total_reg            <= total_reg - CB'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            stq_pkg::S_IDLE: begin
                if (accept) begin
                    slot_reg      <= in_slot;
                    bad_arg_reg   <= bad_arg;
                    bad_state_reg <= bad_state && !bad_arg;
                    pos_reg       <= '0;
                    cnt_reg       <= '0;
                    if (in_func == stq_pkg::FUNC_INSERT) begin
                        key_reg  <= sum;
                        lsel_reg <= wrapped ? !cur_reg : cur_reg;
                    end else if (in_func == stq_pkg::FUNC_REMOVE) begin
                        lsel_reg <= inlist_reg[in_slot];
                    end else if (in_func == stq_pkg::FUNC_ADVANCE) begin
                        key_reg  <= in_now;
                        lsel_reg <= time_back ? !cur_reg : cur_reg;
                    end
                end
            end
            stq_pkg::S_INS_SCAN: begin
                if (scan_end || key_lt) begin
                    for (int i = 0; i < N; i++) begin
                        if (CB'(i) == pos_reg) begin
                            order_reg[lsel_reg][i] <= slot_reg;
                        end else if (i > 0 && CB'(i) > pos_reg && CB'(i) <= cur_len) begin
                            order_reg[lsel_reg][i] <= order_reg[lsel_reg][i-1];
                        end
                    end
                    inlist_reg[slot_reg] <= lsel_reg;
                    wake_reg[slot_reg]   <= key_reg;
                end else begin
                    pos_reg <= pos_reg + CB'(1);
                end
            end
            stq_pkg::S_REM_SCAN: begin
                if (scan_end || scan_slot == slot_reg) begin
                    if (!scan_end) begin
                        for (int i = 0; i < N - 1; i++) begin
                            if (CB'(i) >= pos_reg) begin
                                order_reg[lsel_reg][i] <= order_reg[lsel_reg][i+1];
                            end
                        end
                    end
                end else begin
                    pos_reg <= pos_reg + CB'(1);
                end
            end
            stq_pkg::S_ADV_SCAN: begin
                // The due entries form a prefix of the sorted list; count them first.
                if (!scan_end && !key_lt) begin
                    cnt_reg <= cnt_reg + CB'(1);
                    pos_reg <= pos_reg + CB'(1);
                end
            end
            stq_pkg::S_ADV_EMIT: begin
                if (res_ready) begin
                    for (int i = 0; i < N - 1; i++) begin
                        order_reg[lsel_reg][i] <= order_reg[lsel_reg][i+1];
                    end
                    cnt_reg <= cnt_reg - CB'(1);
                end
            end
            default: begin
            end
        endcase
    end
endmodule

// ===== src/sorted_timeout_queue.sv =====
// The core handles one request at a time: it takes a new request only once the last one has
// sent all its result beats, and result stalls hold it longer. Reset (aresetn, synchronous,
// active low) disarms every slot, empties both lists and clears the stored time; a start
// time write also disarms every slot and empties both lists, but loads the stored time
// from cfg_wr_data.
module sorted_timeout_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [3:0]  s_slot_id,
    input  logic [31:0] s_delay,
    input  logic [31:0] s_now_tick,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_expired_valid,
    output logic [3:0]  m_expired_slot,
    output logic [31:0] m_expired_wake,
    output logic        m_last_result,
    output logic [4:0]  m_pending_count,
    output logic [31:0] m_stored_time
);
    // The core sequences one item; the output register parts it from the sink.
    // An insert walks its target list one entry per cycle with the shared compare
    // until it finds the first later wake tick, and a remove walks until it finds
    // its slot. An advance first counts the due entries at the head of the current
    // list, then sends one beat per expired slot, popping the head on each beat.
    logic             res_valid, res_ready;
    stq_pkg::result_t res_data, out_data;

    stq_core u_core (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(s_valid), .in_ready(s_ready),
        .in_func(s_func), .in_slot(s_slot_id), .in_delay(s_delay), .in_now(s_now_tick),
        .res_valid(res_valid), .res_ready(res_ready), .res_data(res_data)
    );

    // The register holds a beat while the sink stalls, so the core simply waits.
    stq_outreg u_out (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(res_valid), .in_ready(res_ready), .in_data(res_data),
        .out_valid(m_valid), .out_ready(m_ready), .out_data(out_data)
    );

    assign m_status        = out_data.status;
    assign m_expired_valid = out_data.expired_valid;
    assign m_expired_slot  = out_data.expired_slot;
    assign m_expired_wake  = out_data.expired_wake;
    assign m_last_result   = out_data.last_result;
    assign m_pending_count = out_data.pending_count;
    assign m_stored_time   = out_data.stored_time;
endmodule

// ===== src/stq_checker.sv =====
`include "sorted_timeout_queue_macros.svh"
module stq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic        m_expired_valid,
    input logic        m_last_result,
    input logic [4:0]  m_pending_count
);
    `STQ_ASSERT_IMP(a_exp_ok, aclk, aresetn, m_valid && m_expired_valid, m_status == stq_pkg::ST_OK)
    `STQ_ASSERT_IMP(a_cnt, aclk, aresetn, m_valid, m_pending_count <= 5'd16)
    `STQ_ASSERT_IMP(a_err_last, aclk, aresetn, m_valid && m_status != stq_pkg::ST_OK, m_last_result)
    `STQ_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
endmodule

bind sorted_timeout_queue stq_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_status(m_status), .m_expired_valid(m_expired_valid),
    .m_last_result(m_last_result), .m_pending_count(m_pending_count)
);
